FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They compile away when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define PNQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("%m: assertion failed");
// Expression must never be true outside reset.
`define PNQ_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("%m: forbidden condition seen");
`else
`define PNQ_ASSERT(label, clk, rst_n, prop)
`define PNQ_NEVER(label, clk, rst_n, expr)
`endif
`endif

FILE: hw/rtl/pnq_pkg.sv
// ----------------------------------------------------------------------------
// pnq_pkg
// Types and constants shared by the palette quantizer modules.
// ----------------------------------------------------------------------------
package pnq_pkg;

    // Palette geometry.
    localparam int PALETTE_ENTRIES = 256;
    localparam int LIMITED_ENTRIES = 224;
    localparam int LIMIT_LOW       = (LIMITED_ENTRIES < PALETTE_ENTRIES) ?
                                     LIMITED_ENTRIES : PALETTE_ENTRIES;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
    localparam int CNT_W           = $clog2(PALETTE_ENTRIES + 1);

    // Field widths.
    localparam int COLOR_W   = 8;
    localparam int ENTRY_W   = 3 * COLOR_W;
    localparam int SQ_W      = 2 * COLOR_W;
    localparam int DIST_W    = SQ_W + 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 8;

    // Fixed values.
    localparam logic [COLOR_W-1:0] ALPHA_OPAQUE_MIN  = 8'd128;
    localparam logic [7:0]         TRANSPARENT_RESET = 8'd255;
    localparam logic               MODE_LOAD         = 1'b0;
    localparam logic               MODE_PIXEL        = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FULLBRIGHT    = 2'd0,
        CFG_TRANSPARENT   = 2'd1,
        CFG_PALETTE_VALID = 2'd2
    } cfg_idx_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // Input item.
    typedef struct packed {
        logic               mode;
        logic [7:0]         entry_index;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] alpha;
    } pnq_in_t;

    // Result item.
    typedef struct packed {
        logic [7:0] palette_index;
        logic       was_transparent;
    } pnq_out_t;

    // Pixel color held during a search.
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } pnq_color_t;

    // Entry arriving from the palette memory.
    typedef struct packed {
        logic       vld;
        logic [7:0] idx;
    } pnq_probe_t;

    // Running search status.
    typedef struct packed {
        logic       busy;
        logic       found;
        logic [7:0] idx;
    } pnq_best_t;

endpackage

FILE: hw/rtl/pnq_ram.sv
// ----------------------------------------------------------------------------
// pnq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pnq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/pnq_dist.sv
// ----------------------------------------------------------------------------
// pnq_dist
// Weighted color distance pipeline and running minimum tracker.
// ----------------------------------------------------------------------------
module pnq_dist (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           clear,
    input  pnq_pkg::pnq_probe_t            probe,
    input  logic [pnq_pkg::ENTRY_W-1:0]    entry,
    input  pnq_pkg::pnq_color_t            pixel,
    output pnq_pkg::pnq_best_t             best
);
    import pnq_pkg::*;

    logic [SQ_W-1:0]   dr2_reg, dg2_reg, db2_reg;
    logic [SQ_W-1:0]   dr2_next, dg2_next, db2_next;
    logic              s2_vld_reg;
    logic [7:0]        s2_idx_reg;
    logic [DIST_W-1:0] weighted_sum;
    logic [DIST_W-1:0] best_dist_reg, best_dist_next;
    logic              found_reg, found_next;
    logic [7:0]        best_idx_reg, best_idx_next;
    logic              take;

    // Absolute difference of two color channels.
    function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                    input logic [COLOR_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Stage one: per-channel squared differences.
    always_comb
    begin
        logic [COLOR_W-1:0] dr, dg, db;
        dr       = abs_diff(entry[3*COLOR_W-1:2*COLOR_W], pixel.red);
        dg       = abs_diff(entry[2*COLOR_W-1:COLOR_W], pixel.green);
        db       = abs_diff(entry[COLOR_W-1:0], pixel.blue);
        dr2_next = SQ_W'(dr) * SQ_W'(dr);
        dg2_next = SQ_W'(dg) * SQ_W'(dg);
        db2_next = SQ_W'(db) * SQ_W'(db);
    end

    always_ff @(posedge clk)
    begin
        dr2_reg    <= dr2_next;
        dg2_reg    <= dg2_next;
        db2_reg    <= db2_next;
        s2_idx_reg <= probe.idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s2_vld_reg <= probe.vld;
        end
    end

    // Stage two: weighted sum 2*dr^2 + 4*dg^2 + 3*db^2 and compare.
    assign weighted_sum = (DIST_W'(dr2_reg) << 1) + (DIST_W'(dg2_reg) << 2)
                        + (DIST_W'(db2_reg) << 1) + DIST_W'(db2_reg);

    // A strict compare keeps the lowest index on a tie.
    assign take = s2_vld_reg && (!found_reg || (weighted_sum < best_dist_reg));

    always_comb
    begin
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        if (clear)
        begin
            found_next = 1'b0;
        end
        else if (take)
        begin
            found_next     = 1'b1;
            best_idx_next  = s2_idx_reg;
            best_dist_next = weighted_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    assign best.busy  = s2_vld_reg;
    assign best.found = found_reg;
    assign best.idx   = best_idx_reg;

endmodule

FILE: hw/rtl/palette_nearest_color_quantizer.sv
// ----------------------------------------------------------------------------
// palette_nearest_color_quantizer
// Maps RGBA pixels to the nearest entry of a 256-color palette.
// ----------------------------------------------------------------------------
// A load item (mode 0) writes one palette entry and gives no result. A pixel
// item (mode 1) gives one result. Transparent pixels and pixels seen while no
// palette is valid skip the search and go from the accepting cycle to the
// hand-over of the result. Any other pixel scans the palette memory through
// its single read port, one entry per cycle, over the search length (224
// entries, or 256 with fullbright colors allowed): after the accepting cycle
// come the scan, the pipeline drain and the hand-over of the result. The
// drain ends sooner when the last searched entry is the transparent one. A
// finished result waits in an output register, so a new item can be accepted
// while the previous result is still stalled; the hand-over cycle is extended
// only while that register still holds an unaccepted result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module palette_nearest_color_quantizer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  pnq_pkg::pnq_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output pnq_pkg::pnq_out_t             out_data,
    input  logic                          cfg_write,
    input  logic [pnq_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pnq_pkg::CFG_W-1:0]     cfg_data
);
    import pnq_pkg::*;

    state_t          state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] limit;
    logic            last_issue;
    logic            in_xfer;
    logic            pixel_start;
    logic            fast_path;
    logic            issue;
    logic            load_out;
    logic            pipe_empty;

    logic            fullbright_reg;
    logic [7:0]      transparent_reg;
    logic            pal_valid_reg;

    pnq_color_t      pixel_reg;
    pnq_out_t        res_reg, res_next;
    logic            out_valid_reg, out_valid_next;
    pnq_out_t        out_data_reg;

    logic            ram_wr_en;
    logic [ENTRY_W-1:0] ram_rd_data;
    pnq_probe_t      probe_reg, probe_next;
    pnq_best_t       best;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fullbright_reg  <= 1'b0;
            transparent_reg <= TRANSPARENT_RESET;
            pal_valid_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_FULLBRIGHT:    fullbright_reg  <= cfg_data[0];
                CFG_TRANSPARENT:   transparent_reg <= cfg_data[7:0];
                CFG_PALETTE_VALID: pal_valid_reg   <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Input transfer decode.
    assign in_xfer     = in_valid && !in_stall;
    assign pixel_start = in_xfer && (in_data.mode == MODE_PIXEL);
    assign fast_path   = (in_data.alpha < ALPHA_OPAQUE_MIN) || !pal_valid_reg;
    assign ram_wr_en   = in_xfer && (in_data.mode == MODE_LOAD)
                         && (9'(in_data.entry_index) < 9'(PALETTE_ENTRIES));

    // Search bounds.
    assign limit      = fullbright_reg ? CNT_W'(PALETTE_ENTRIES) : CNT_W'(LIMIT_LOW);
    assign last_issue = (cnt_reg == limit - CNT_W'(1));
    assign pipe_empty = !probe_reg.vld && !best.busy;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pixel_start)
                begin
                    state_next = fast_path ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output decode of the controller.
    always_comb
    begin
        in_stall = 1'b1;
        issue    = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:   in_stall = 1'b0;
            ST_SCAN:   issue    = 1'b1;
            ST_DRAIN:  ;
            ST_FINISH: load_out = !out_valid_reg || !out_stall;
            default:   ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Scan counter.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (pixel_start)
        begin
            cnt_next = '0;
        end
        else if (issue)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Read tag that travels with the memory latency; the transparent entry is skipped.
    assign probe_next.vld = issue && (8'(cnt_reg[IDX_W-1:0]) != transparent_reg);
    assign probe_next.idx = 8'(cnt_reg[IDX_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
        end
        else
        begin
            probe_reg <= probe_next;
        end
    end

    // Palette memory.
    pnq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_palette (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (in_data.entry_index[IDX_W-1:0]),
        .wr_data ({in_data.red, in_data.green, in_data.blue}),
        .rd_en   (issue),
        .rd_addr (cnt_reg[IDX_W-1:0]),
        .rd_data (ram_rd_data)
    );

    // Distance pipeline and minimum tracker.
    pnq_dist u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (pixel_start),
        .probe (probe_reg),
        .entry (ram_rd_data),
        .pixel (pixel_reg),
        .best  (best)
    );

    // Pixel color and pending result.
    always_comb
    begin
        res_next = res_reg;
        if (pixel_start)
        begin
            if (in_data.alpha < ALPHA_OPAQUE_MIN)
            begin
                res_next.palette_index   = transparent_reg;
                res_next.was_transparent = 1'b1;
            end
            else
            begin
                res_next.palette_index   = '0;
                res_next.was_transparent = 1'b0;
            end
        end
        else if ((state_reg == ST_DRAIN) && pipe_empty)
        begin
            res_next.palette_index   = best.found ? best.idx : 8'd0;
            res_next.was_transparent = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (pixel_start)
        begin
            pixel_reg <= '{red: in_data.red, green: in_data.green, blue: in_data.blue};
        end
    end

    // Output register.
    assign out_valid_next = load_out || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The scan never addresses past the search limit.
    `PNQ_ASSERT(a_scan_in_range, clk, rst_n, (state_reg == ST_SCAN) |-> (cnt_reg < limit))
    // A new result appears only after the controller finished an item.
    `PNQ_ASSERT(a_result_from_finish, clk, rst_n,
        $rose(out_valid_reg) |-> $past(state_reg == ST_FINISH))
    // Memory reads in flight only while a search is running.
    `PNQ_ASSERT(a_probe_in_search, clk, rst_n,
        (probe_reg.vld || best.busy) |-> ((state_reg == ST_SCAN) || (state_reg == ST_DRAIN)))
    // The transparent entry never enters the search pipeline.
    `PNQ_NEVER(a_skip_transparent, clk, rst_n,
        probe_reg.vld && (probe_reg.idx == transparent_reg))

endmodule

FILE: bench/tb_palette_nearest_color_quantizer.sv
// ----------------------------------------------------------------------------
// tb_palette_nearest_color_quantizer
// Self-checking bench for the nearest-palette color quantizer. Palette loads
// and RGBA pixels are streamed in with random sender gaps and receiver stalls.
// Each returned index is checked against a local nearest-color search over
// a shadow copy of the palette and the current register settings.
// ----------------------------------------------------------------------------
module tb_palette_nearest_color_quantizer;
    timeunit 1ns;
    timeprecision 1ps;

    import pnq_pkg::*;

    localparam int QUIET_LIMIT   = 6000;
    localparam int LONG_HOLD     = 1500;
    localparam int SETTLE_CYCLES = 10;
    localparam int DRAIN_CYCLES  = 300;
    localparam int PHASE_ITEMS   = 210;
    localparam int REPORT_MAX    = 10;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    pnq_in_t              in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    pnq_out_t             out_data;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Register copies and palette shadow used for prediction.
    logic       fullbright_cfg  = 1'b0;
    logic [7:0] transparent_cfg = TRANSPARENT_RESET;
    logic       palette_on_cfg  = 1'b0;
    pnq_color_t palette_shadow [PALETTE_ENTRIES];

    // Palette as the stimulus generator has queued it.
    pnq_color_t queued_palette [PALETTE_ENTRIES];

    pnq_in_t    stream_queue [$];
    pnq_out_t   pending_results [$];

    logic in_taken = 1'b0;
    bit   calm     = 1'b0;

    int items_accepted     = 0;
    int loads_accepted     = 0;
    int pixels_accepted    = 0;
    int searches_predicted = 0;
    int transparent_seen   = 0;
    int results_checked    = 0;
    int mismatch_count     = 0;
    int settings_applied   = 0;
    int quiet_cycles       = 0;

    int  gap_left       = 0;
    int  stall_left     = 0;
    int  open_left      = 0;
    int  long_hold_left = 0;
    bit  long_hold_done = 1'b0;

    palette_nearest_color_quantizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with a 12 ns period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Weighted squared color distance between a palette entry and a pixel.
    function automatic int weighted_distance(pnq_color_t entry, pnq_in_t px);
        int dr;
        int dg;
        int db;
        dr = int'(entry.red)   - int'(px.red);
        dg = int'(entry.green) - int'(px.green);
        db = int'(entry.blue)  - int'(px.blue);
        return 2 * dr * dr + 4 * dg * dg + 3 * db * db;
    endfunction

    // Expected result for one pixel under the current settings.
    function automatic pnq_out_t quantize_pixel(pnq_in_t px);
        pnq_out_t res;
        int       limit;
        int       best_d;
        int       d;
        res.palette_index   = '0;
        res.was_transparent = 1'b0;
        limit = fullbright_cfg ? PALETTE_ENTRIES : LIMIT_LOW;
        if (px.alpha < ALPHA_OPAQUE_MIN)
        begin
            res.palette_index   = transparent_cfg;
            res.was_transparent = 1'b1;
        end
        else if (palette_on_cfg)
        begin
            // The strict compare keeps the lowest index on a tie.
            best_d = 1 << 30;
            for (int i = 0; i < limit; i++)
            begin
                if (i == int'(transparent_cfg))
                    continue;
                d = weighted_distance(palette_shadow[i], px);
                if (d < best_d)
                begin
                    best_d = d;
                    res.palette_index = 8'(i);
                end
            end
        end
        return res;
    endfunction

    task automatic note_mismatch(string what, pnq_out_t want, pnq_out_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("[%0t] %s: expected index %0d transparent %0b, got index %0d transparent %0b",
                     $realtime, what, want.palette_index, want.was_transparent,
                     got.palette_index, got.was_transparent);
    endtask

    // Sender: presents queued items, with random gaps between transfers.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (stream_queue.size() > 0)
            begin
                in_data  <= stream_queue.pop_front();
                in_valid <= 1'b1;
                if (!calm && $urandom_range(0, 5) == 0)
                    gap_left = $urandom_range(1, 9);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver: random stall bursts, one long hold-off, none when calm.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (!long_hold_done && !calm && results_checked >= 60)
            begin
                long_hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (long_hold_left > 0)
            begin
                long_hold_left--;
                out_stall <= 1'b1;
            end
            else if (calm)
                out_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (open_left > 0)
                    open_left--;
                else
                begin
                    stall_left = $urandom_range(1, 9);
                    open_left  = $urandom_range(0, 40);
                end
            end
        end
    end

    // Monitor: predicts on each input transfer and checks each result transfer.
    always @(posedge clk)
    begin : monitor
        pnq_out_t want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_valid && !in_stall;
            if (in_valid && !in_stall)
            begin
                items_accepted++;
                if (in_data.mode == MODE_LOAD)
                begin
                    loads_accepted++;
                    palette_shadow[in_data.entry_index] =
                        {in_data.red, in_data.green, in_data.blue};
                end
                else
                begin
                    pixels_accepted++;
                    if (in_data.alpha < ALPHA_OPAQUE_MIN)
                        transparent_seen++;
                    else if (palette_on_cfg)
                        searches_predicted++;
                    pending_results.push_back(quantize_pixel(in_data));
                end
            end
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (pending_results.size() == 0)
                    note_mismatch("unexpected result", '0, out_data);
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.palette_index !== want.palette_index)
                        note_mismatch("palette_index differs", want, out_data);
                    else if (out_data.was_transparent !== want.was_transparent)
                        note_mismatch("was_transparent differs", want, out_data);
                end
            end
        end
    end

    // Watchdog on stretches without any transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout after %0d cycles without a transfer", quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // Queue one item and track what the palette will hold once it is taken.
    task automatic push_item(pnq_in_t item);
        if (item.mode == MODE_LOAD)
            queued_palette[item.entry_index] = {item.red, item.green, item.blue};
        stream_queue.push_back(item);
    endtask

    task automatic push_load(logic [7:0] idx, pnq_color_t c);
        pnq_in_t item;
        item.mode        = MODE_LOAD;
        item.entry_index = idx;
        item.red         = c.red;
        item.green       = c.green;
        item.blue        = c.blue;
        item.alpha       = 8'($urandom);
        push_item(item);
    endtask

    task automatic push_pixel(pnq_color_t c, logic [7:0] a);
        pnq_in_t item;
        item.mode        = MODE_PIXEL;
        item.entry_index = 8'($urandom);
        item.red         = c.red;
        item.green       = c.green;
        item.blue        = c.blue;
        item.alpha       = a;
        push_item(item);
    endtask

    // Palette colors: a few shared colors produce ties, the rest are random.
    function automatic pnq_color_t palette_color();
        pnq_color_t c;
        if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 3))
                0:       c = 24'h000000;
                1:       c = 24'hFFFFFF;
                2:       c = 24'h808080;
                default: c = 24'h20C040;
            endcase
        end
        else
            c = 24'($urandom);
        return c;
    endfunction

    // Pixel colors: half land on or next to a queued palette entry.
    function automatic pnq_color_t pixel_color();
        pnq_color_t c;
        if ($urandom_range(0, 1) == 1)
        begin
            c = queued_palette[$urandom_range(0, PALETTE_ENTRIES - 1)];
            if ($urandom_range(0, 1) == 1)
                c = pnq_color_t'(c ^ (24'($urandom) & 24'h030303));
        end
        else
            c = 24'($urandom);
        return c;
    endfunction

    function automatic logic [7:0] pixel_alpha();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 127));
        return 8'($urandom_range(128, 255));
    endfunction

    // Short runs of loads followed by pixel bursts, with some raw noise items.
    task automatic random_traffic(int count);
        int      made;
        int      n;
        pnq_in_t item;
        made = 0;
        while (made < count)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                item.mode        = 1'($urandom_range(0, 1));
                item.entry_index = 8'($urandom);
                item.red         = 8'($urandom);
                item.green       = 8'($urandom);
                item.blue        = 8'($urandom);
                item.alpha       = 8'($urandom);
                push_item(item);
                made++;
            end
            else
            begin
                n = $urandom_range(0, 3);
                repeat (n)
                    push_load(8'($urandom), palette_color());
                made += n;
                n = $urandom_range(1, 6);
                repeat (n)
                    push_pixel(pixel_color(), pixel_alpha());
                made += n;
            end
        end
    endtask

    // Waits until the block is idle, then writes all three registers.
    task automatic reconfigure(logic fb, logic [7:0] tr, logic on);
        while (stream_queue.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_FULLBRIGHT;
        cfg_data  <= CFG_W'(fb);
        @(negedge clk);
        cfg_index <= CFG_TRANSPARENT;
        cfg_data  <= tr;
        @(negedge clk);
        cfg_index <= CFG_PALETTE_VALID;
        cfg_data  <= CFG_W'(on);
        @(negedge clk);
        cfg_write <= 1'b0;
        fullbright_cfg  = fb;
        transparent_cfg = tr;
        palette_on_cfg  = on;
        settings_applied++;
    endtask

    // Stimulus sequence.
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // No palette yet: transparent and opaque pixels at the alpha threshold.
        push_pixel(24'h000000, 8'd0);
        push_pixel(24'hFFFFFF, 8'd127);
        push_pixel(24'h000000, 8'd128);
        push_pixel(24'hFFFFFF, 8'd255);

        // Fill every entry before any search: black first, white at the top.
        for (int i = 0; i < PALETTE_ENTRIES; i++)
        begin
            if (i == 0)
                push_load(8'(i), 24'h000000);
            else if (i >= PALETTE_ENTRIES - 2)
                push_load(8'(i), 24'hFFFFFF);
            else
                push_load(8'(i), palette_color());
        end

        // Limited search with the transparent index at the top.
        reconfigure(1'b0, 8'd255, 1'b1);
        push_pixel(24'h000000, 8'd200);
        push_pixel(24'hFFFFFF, 8'd128);
        push_pixel(24'hFFFFFF, 8'd127);
        push_pixel(queued_palette[100], 8'd255);

        // Full search reaches the white entries above the limited range.
        reconfigure(1'b1, 8'd255, 1'b1);
        push_pixel(24'hFFFFFF, 8'd255);
        push_pixel(queued_palette[230], 8'd129);

        // Transparent index at entry 0 hides the black entry.
        reconfigure(1'b1, 8'd0, 1'b1);
        push_pixel(24'h000000, 8'd255);
        push_pixel(24'h000000, 8'd5);

        // Transparent index on one of the two white entries.
        reconfigure(1'b1, 8'd254, 1'b1);
        push_pixel(24'hFFFFFF, 8'd255);
        push_pixel(24'hFEFFFF, 8'd130);

        // Palette marked absent while transparent index is 0.
        reconfigure(1'b0, 8'd0, 1'b0);
        push_pixel(24'h123456, 8'd0);
        push_pixel(24'hFFFFFF, 8'd255);

        // Random phases over several register settings.
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                0: reconfigure(1'b0, 8'd255, 1'b1);
                1: reconfigure(1'b1, 8'd255, 1'b1);
                2: reconfigure(1'b1, 8'd0, 1'b1);
                3: reconfigure(1'b0, 8'd223, 1'b1);
                4: reconfigure(1'b0, 8'd0, 1'b0);
                5: reconfigure(1'b1, 8'($urandom), 1'b1);
                6: reconfigure(1'b0, 8'($urandom_range(0, 223)), 1'b1);
                default:
                begin
                    reconfigure(1'b1, 8'($urandom), 1'b1);
                    calm = 1'b1;
                end
            endcase
            random_traffic(PHASE_ITEMS);
        end

        // Drain, then allow time for any stray result.
        while (stream_queue.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d transfers in: %0d palette loads, %0d pixels (%0d searches, %0d transparent)",
                 items_accepted, loads_accepted, pixels_accepted,
                 searches_predicted, transparent_seen);
        $display("Checked %0d results over %0d register settings, %0d failing",
                 results_checked, settings_applied, mismatch_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
